// ----- hw/rtl/lssu_pkg.sv -----
package lssu_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LINK = 2'd1;
  localparam logic [1:0] CMD_CAL  = 2'd2;

  // link status codes
  localparam logic [1:0] LINK_FAILED     = 2'd0;
  localparam logic [1:0] LINK_ATTEMPTING = 2'd1;
  localparam logic [1:0] LINK_CONNECTED  = 2'd2;

  // request flag bit positions
  localparam int unsigned FLAG_CAL     = 0;
  localparam int unsigned FLAG_FAILED  = 1;
  localparam int unsigned FLAG_ATTEMPT = 2;
  localparam int unsigned FLAG_CONN    = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL  = 3'd5;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration reset values
  localparam logic [3:0] RST_BLINK_COUNT = 4'd5;
  localparam logic [7:0] RST_BLINK_HALF  = 8'd100;
  localparam logic [7:0] RST_FAST_STEP   = 8'd20;
  localparam logic [7:0] RST_MID_STEP    = 8'd30;
  localparam logic [7:0] RST_SLOW_STEP   = 8'd40;
  localparam logic [7:0] RST_PEAK_LEVEL  = 8'd80;

  // breathing level thresholds for frame delay
  localparam logic [7:0] LEVEL_FAST_ABOVE = 8'd40;
  localparam logic [7:0] LEVEL_MID_ABOVE  = 8'd20;

  // level steps
  localparam logic [7:0] STEP_CAL     = 8'd1;
  localparam logic [7:0] STEP_ATTEMPT = 8'd2;

  // blink colors, packed red/green/blue
  localparam logic [23:0] COLOR_OFF       = 24'h000000;
  localparam logic [23:0] COLOR_FAILED    = {8'd120, 8'd0, 8'd0};
  localparam logic [23:0] COLOR_CONNECTED = {8'd0, 8'd30, 8'd0};

  typedef enum logic [2:0] {
    FX_IDLE      = 3'd0,
    FX_CAL       = 3'd1,
    FX_FAILED    = 3'd2,
    FX_ATTEMPT   = 3'd3,
    FX_CONNECTED = 3'd4
  } effect_e;

  typedef struct packed {
    logic [3:0] blink_count;
    logic [7:0] blink_half;
    logic [7:0] fast_step;
    logic [7:0] mid_step;
    logic [7:0] slow_step;
    logic [7:0] peak_level;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       refresh;
  } result_t;

endpackage

// ----- hw/rtl/lssu_if.sv -----
// input item channel
interface lssu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] link_status;
  logic       calibrating;

  modport source (output valid, cmd, link_status, calibrating, input ready);
  modport sink (input valid, cmd, link_status, calibrating, output ready);
endinterface

// result item channel
interface lssu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       refresh;

  modport source (output valid, red, green, blue, refresh, input ready);
  modport sink (input valid, red, green, blue, refresh, output ready);
endinterface

// ----- hw/rtl/led_status_animation_sequencer_unit.sv -----
// Status LED animation sequencer.
// Input channel in_i carries one item per handshake: a 1 ms tick, a link
// status update or a calibration update. Output channel out_o returns one
// result item per input item: the current strip color and a refresh flag
// that is set when that tick wrote a new frame to the strip.
// An accepted item waits in the input register until the result register is
// free or drains, is then processed, and its result is offered on out_o
// from the result register.
// Throughput: one item per cycle while out_o takes results; the input
// register, the state update and the result register form a two-stage
// pipeline with all effect logic combinational between them.
// Stalls: while out_o is held, one more item waits in the input register;
// after that in_i.ready drops until the result is taken.
// Reset (rst_ni low, asynchronous): no requests, idle effect, LED off and
// all configuration registers at their reset values.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
// the next edge and are meant to be made while the block is idle.
module led_status_animation_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lssu_in_if.sink                          in_i,
  lssu_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [lssu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lssu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  lssu_pkg::cfg_t    cfg;
  lssu_pkg::result_t res;
  lssu_pkg::result_t res_q;

  logic       in_vld_q;
  logic [1:0] cmd_q;
  logic [1:0] link_status_q;
  logic       calibrating_q;
  logic       out_vld_q;
  logic       proc;

  // the held item moves on when the result register is free or drains now
  assign proc       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || proc;

  lssu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q         <= in_i.cmd;
      link_status_q <= in_i.link_status;
      calibrating_q <= in_i.calibrating;
    end
  end

  lssu_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .proc_i        (proc),
    .cmd_i         (cmd_q),
    .link_status_i (link_status_q),
    .calibrating_i (calibrating_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.red     = res_q.red;
  assign out_o.green   = res_q.green;
  assign out_o.blue    = res_q.blue;
  assign out_o.refresh = res_q.refresh;

`ifndef ASSERT_OFF
  // input is only held off when both registers are full and the output stalls
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without output back-pressure");

  // every processed item shows up as a result in the next cycle
  a_proc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("processed item produced no result");
`endif

endmodule

// ----- hw/rtl/lssu_cfg_regs.sv -----
module lssu_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lssu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lssu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output lssu_pkg::cfg_t                   cfg_o
);

  lssu_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lssu_pkg::CFG_BLINK_COUNT: cfg_d.blink_count = cfg_wdata_i[3:0];
        lssu_pkg::CFG_BLINK_HALF:  cfg_d.blink_half  = cfg_wdata_i;
        lssu_pkg::CFG_FAST_STEP:   cfg_d.fast_step   = cfg_wdata_i;
        lssu_pkg::CFG_MID_STEP:    cfg_d.mid_step    = cfg_wdata_i;
        lssu_pkg::CFG_SLOW_STEP:   cfg_d.slow_step   = cfg_wdata_i;
        lssu_pkg::CFG_PEAK_LEVEL:  cfg_d.peak_level  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_count <= lssu_pkg::RST_BLINK_COUNT;
      cfg_q.blink_half  <= lssu_pkg::RST_BLINK_HALF;
      cfg_q.fast_step   <= lssu_pkg::RST_FAST_STEP;
      cfg_q.mid_step    <= lssu_pkg::RST_MID_STEP;
      cfg_q.slow_step   <= lssu_pkg::RST_SLOW_STEP;
      cfg_q.peak_level  <= lssu_pkg::RST_PEAK_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/lssu_core.sv -----
module lssu_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  proc_i,
  input  logic [1:0]            cmd_i,
  input  logic [1:0]            link_status_i,
  input  logic                  calibrating_i,
  input  lssu_pkg::cfg_t        cfg_i,
  output lssu_pkg::result_t     res_o
);

  logic [3:0]        flags_q, flags_d;
  lssu_pkg::effect_e fx_q, fx_d, fx_live, fx_sel;
  logic [7:0]        level_q, level_d;
  logic              rising_q, rising_d;
  logic [7:0]        wait_q, wait_d;
  logic [3:0]        blinks_q, blinks_d;
  logic              lit_q, lit_d;
  logic [23:0]       color_q, color_d;

  logic       is_tick;
  logic [7:0] wait_dec;
  logic       tick_due;
  logic       start;
  logic       blink_done;
  logic       refresh;

  // working values of the frame
  logic [7:0] lv_base;
  logic       rs_base;
  logic [7:0] step;
  logic [8:0] lv_sum;
  logic [7:0] lv_new;
  logic [3:0] bl_base;
  logic       lit_base;
  logic [23:0] on_color;

  assign is_tick  = (cmd_i == lssu_pkg::CMD_TICK);
  assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : 8'd0;
  assign tick_due = proc_i && is_tick && (wait_dec == 8'd0);

  // effect selection: drop a breathing effect whose request went away, pick when idle
  always_comb begin
    fx_live = fx_q;
    if (fx_q == lssu_pkg::FX_CAL && !flags_q[lssu_pkg::FLAG_CAL]) begin
      fx_live = lssu_pkg::FX_IDLE;
    end
    if (fx_q == lssu_pkg::FX_ATTEMPT && !flags_q[lssu_pkg::FLAG_ATTEMPT]) begin
      fx_live = lssu_pkg::FX_IDLE;
    end
    fx_sel = fx_live;
    start  = 1'b0;
    if (fx_live == lssu_pkg::FX_IDLE) begin
      start = 1'b1;
      priority if (flags_q[lssu_pkg::FLAG_CAL]) begin
        fx_sel = lssu_pkg::FX_CAL;
      end else if (flags_q[lssu_pkg::FLAG_FAILED]) begin
        fx_sel = lssu_pkg::FX_FAILED;
      end else if (flags_q[lssu_pkg::FLAG_ATTEMPT]) begin
        fx_sel = lssu_pkg::FX_ATTEMPT;
      end else if (flags_q[lssu_pkg::FLAG_CONN]) begin
        fx_sel = lssu_pkg::FX_CONNECTED;
      end else begin
        start = 1'b0;
      end
    end
  end

  // next effect
  always_comb begin
    fx_d = fx_q;
    if (tick_due) begin
      fx_d = blink_done ? lssu_pkg::FX_IDLE : fx_sel;
    end
  end

  // frame datapath and request flags
  always_comb begin
    flags_d    = flags_q;
    level_d    = level_q;
    rising_d   = rising_q;
    wait_d     = wait_q;
    blinks_d   = blinks_q;
    lit_d      = lit_q;
    color_d    = color_q;
    blink_done = 1'b0;
    refresh    = 1'b0;

    lv_base  = start ? 8'd0 : level_q;
    rs_base  = start ? 1'b1 : rising_q;
    lit_base = start ? 1'b0 : lit_q;
    bl_base  = start ? ((cfg_i.blink_count == 4'd0) ? 4'd1 : cfg_i.blink_count) : blinks_q;
    step     = (fx_sel == lssu_pkg::FX_ATTEMPT) ? lssu_pkg::STEP_ATTEMPT : lssu_pkg::STEP_CAL;
    lv_sum   = {1'b0, lv_base} + {1'b0, step};
    if (rs_base) begin
      lv_new = lv_sum[8] ? 8'hFF : lv_sum[7:0];
    end else begin
      lv_new = (lv_base < step) ? 8'd0 : lv_base - step;
    end
    on_color = (fx_sel == lssu_pkg::FX_FAILED) ? lssu_pkg::COLOR_FAILED
                                                : lssu_pkg::COLOR_CONNECTED;

    if (proc_i) begin
      unique case (cmd_i)
        lssu_pkg::CMD_LINK: begin
          unique case (link_status_i)
            lssu_pkg::LINK_FAILED:     flags_d = {3'b001, flags_q[lssu_pkg::FLAG_CAL]};
            lssu_pkg::LINK_ATTEMPTING: flags_d = {3'b010, flags_q[lssu_pkg::FLAG_CAL]};
            lssu_pkg::LINK_CONNECTED:  flags_d = {3'b100, flags_q[lssu_pkg::FLAG_CAL]};
            default: ;
          endcase
        end
        lssu_pkg::CMD_CAL: begin
          flags_d[lssu_pkg::FLAG_CAL] = calibrating_i;
        end
        lssu_pkg::CMD_TICK: begin
          wait_d = wait_dec;
        end
        default: ;
      endcase
    end

    if (tick_due && fx_sel != lssu_pkg::FX_IDLE) begin
      refresh = 1'b1;
      // state of an effect that starts now
      level_d  = lv_base;
      rising_d = rs_base;
      lit_d    = lit_base;
      blinks_d = bl_base;
      unique case (fx_sel)
        lssu_pkg::FX_CAL, lssu_pkg::FX_ATTEMPT: begin
          if (fx_sel == lssu_pkg::FX_ATTEMPT) begin
            color_d = {lv_base, 1'b0, lv_base[7:1], 8'd0};
          end else begin
            color_d = {16'd0, lv_base};
          end
          level_d = lv_new;
          if (lv_new >= cfg_i.peak_level) begin
            rising_d = 1'b0;
          end else if (lv_new == 8'd0) begin
            rising_d = 1'b1;
          end
          if (lv_new > lssu_pkg::LEVEL_FAST_ABOVE) begin
            wait_d = cfg_i.fast_step;
          end else if (lv_new > lssu_pkg::LEVEL_MID_ABOVE) begin
            wait_d = cfg_i.mid_step;
          end else begin
            wait_d = cfg_i.slow_step;
          end
        end
        lssu_pkg::FX_FAILED, lssu_pkg::FX_CONNECTED: begin
          priority if (lit_base) begin
            color_d = lssu_pkg::COLOR_OFF;
            lit_d   = 1'b0;
            if (bl_base != 4'd0) begin
              blinks_d = bl_base - 4'd1;
            end
            wait_d = cfg_i.blink_half;
          end else if (bl_base != 4'd0) begin
            color_d = on_color;
            lit_d   = 1'b1;
            wait_d  = cfg_i.blink_half;
          end else begin
            // solid color, link requests consumed
            color_d    = on_color;
            flags_d    = {3'b000, flags_q[lssu_pkg::FLAG_CAL]};
            wait_d     = 8'd0;
            blink_done = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= 4'd0;
      fx_q     <= lssu_pkg::FX_IDLE;
      level_q  <= 8'd0;
      rising_q <= 1'b1;
      wait_q   <= 8'd0;
      blinks_q <= 4'd0;
      lit_q    <= 1'b0;
      color_q  <= lssu_pkg::COLOR_OFF;
    end else begin
      flags_q  <= flags_d;
      fx_q     <= fx_d;
      level_q  <= level_d;
      rising_q <= rising_d;
      wait_q   <= wait_d;
      blinks_q <= blinks_d;
      lit_q    <= lit_d;
      color_q  <= color_d;
    end
  end

  // result of the current item
  assign res_o.red     = color_d[23:16];
  assign res_o.green   = color_d[15:8];
  assign res_o.blue    = color_d[7:0];
  assign res_o.refresh = refresh;

`ifndef ASSERT_OFF
  // events never touch the strip color or the running effect
  a_event_keeps_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && !is_tick) |=> $stable(color_q) && $stable(fx_q))
    else $error("event item changed strip color or effect");

  // a tick inside a frame delay only counts down
  a_wait_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && is_tick && wait_q > 8'd1) |=> $stable(color_q) && $stable(fx_q)
      && (wait_q == $past(wait_q) - 8'd1))
    else $error("frame written during delay");

  // a finished blink leaves no link request behind
  a_blink_clears_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_due && blink_done) |=> (flags_q[3:1] == 3'b000) && (fx_q == lssu_pkg::FX_IDLE))
    else $error("link flags left after blink");
`endif

endmodule

// ----- bench/tb_led_status_animation_sequencer_unit.sv -----
module tb_led_status_animation_sequencer_unit;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] LINK_OTHER = 2'd3;

  // run limit in time units
  localparam int unsigned RUN_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [lssu_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [lssu_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  lssu_in_if in_if ();
  lssu_out_if out_if ();

  led_status_animation_sequencer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // directed row: either a register write or an input item
  typedef struct packed {
    logic                           is_cfg;
    logic [lssu_pkg::CFG_IDX_W-1:0] idx;
    logic [7:0]                     data;
    logic [1:0]                     cmd;
    logic [1:0]                     link;
    logic                           cal;
    logic                           typed;
    lssu_pkg::result_t              res;
  } dir_row_t;

  dir_row_t dir_tab[$];

  // animation state as the block should hold it
  lssu_pkg::cfg_t    led_cfg = {lssu_pkg::RST_BLINK_COUNT, lssu_pkg::RST_BLINK_HALF,
                                lssu_pkg::RST_FAST_STEP, lssu_pkg::RST_MID_STEP,
                                lssu_pkg::RST_SLOW_STEP, lssu_pkg::RST_PEAK_LEVEL};
  logic [3:0]        req_flags = '0;
  lssu_pkg::effect_e fx = lssu_pkg::FX_IDLE;
  logic [7:0]        level = '0;
  logic              rising = 1'b1;
  logic [7:0]        wait_cnt = '0;
  logic [3:0]        blinks_left = '0;
  logic              lit = 1'b0;
  logic [23:0]       strip = lssu_pkg::COLOR_OFF;

  // strip results still to come out of the block
  lssu_pkg::result_t strip_q[$];

  int unsigned mismatches = 0;
  bit          in_no_gaps = 1'b0;
  bit          out_no_stall = 1'b0;
  bit          hold_req = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, wanted %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one breathing frame: write color, step the level, pick the delay
  task automatic breathe(input logic [7:0] stp);
    int lv;
    lv = level;
    if (stp == lssu_pkg::STEP_ATTEMPT) begin
      strip = {level, level >> 1, 8'd0};
    end else begin
      strip = {16'd0, level};
    end
    if (rising) begin
      lv = (lv + stp > 255) ? 255 : lv + stp;
    end else begin
      lv = (lv < stp) ? 0 : lv - stp;
    end
    if (lv >= led_cfg.peak_level) begin
      rising = 1'b0;
    end else if (lv == 0) begin
      rising = 1'b1;
    end
    level = lv[7:0];
    if (lv > lssu_pkg::LEVEL_FAST_ABOVE) begin
      wait_cnt = led_cfg.fast_step;
    end else if (lv > lssu_pkg::LEVEL_MID_ABOVE) begin
      wait_cnt = led_cfg.mid_step;
    end else begin
      wait_cnt = led_cfg.slow_step;
    end
  endtask

  // one blink half, or the final solid color
  task automatic blink(input logic [23:0] on_color);
    if (lit) begin
      strip = lssu_pkg::COLOR_OFF;
      lit = 1'b0;
      if (blinks_left != 0) blinks_left = blinks_left - 4'd1;
      wait_cnt = led_cfg.blink_half;
    end else if (blinks_left != 0) begin
      strip = on_color;
      lit = 1'b1;
      wait_cnt = led_cfg.blink_half;
    end else begin
      strip = on_color;
      req_flags[lssu_pkg::FLAG_FAILED] = 1'b0;
      req_flags[lssu_pkg::FLAG_ATTEMPT] = 1'b0;
      req_flags[lssu_pkg::FLAG_CONN] = 1'b0;
      fx = lssu_pkg::FX_IDLE;
      wait_cnt = '0;
    end
  endtask

  // advance the animation by one item and give the strip result
  task automatic animate_step(input logic [1:0] cmd, input logic [1:0] link,
                              input logic cal, output lssu_pkg::result_t r);
    logic frame;
    frame = 1'b0;
    case (cmd)
      lssu_pkg::CMD_LINK: begin
        if (link != LINK_OTHER) begin
          req_flags[lssu_pkg::FLAG_FAILED] = 1'b0;
          req_flags[lssu_pkg::FLAG_ATTEMPT] = 1'b0;
          req_flags[lssu_pkg::FLAG_CONN] = 1'b0;
          req_flags[lssu_pkg::FLAG_FAILED + int'(link)] = 1'b1;
        end
      end
      lssu_pkg::CMD_CAL: req_flags[lssu_pkg::FLAG_CAL] = cal;
      lssu_pkg::CMD_TICK: begin
        if (wait_cnt != 0) wait_cnt = wait_cnt - 8'd1;
        if (wait_cnt == 0) begin
          // breathing ends once its own request is gone
          if (fx == lssu_pkg::FX_CAL && !req_flags[lssu_pkg::FLAG_CAL]) begin
            fx = lssu_pkg::FX_IDLE;
          end
          if (fx == lssu_pkg::FX_ATTEMPT && !req_flags[lssu_pkg::FLAG_ATTEMPT]) begin
            fx = lssu_pkg::FX_IDLE;
          end
          if (fx == lssu_pkg::FX_IDLE) begin
            if (req_flags[lssu_pkg::FLAG_CAL]) fx = lssu_pkg::FX_CAL;
            else if (req_flags[lssu_pkg::FLAG_FAILED]) fx = lssu_pkg::FX_FAILED;
            else if (req_flags[lssu_pkg::FLAG_ATTEMPT]) fx = lssu_pkg::FX_ATTEMPT;
            else if (req_flags[lssu_pkg::FLAG_CONN]) fx = lssu_pkg::FX_CONNECTED;
            if (fx != lssu_pkg::FX_IDLE) begin
              level = '0;
              rising = 1'b1;
              lit = 1'b0;
              blinks_left = (led_cfg.blink_count == 0) ? 4'd1 : led_cfg.blink_count;
            end
          end
          frame = 1'b1;
          case (fx)
            lssu_pkg::FX_CAL:       breathe(lssu_pkg::STEP_CAL);
            lssu_pkg::FX_ATTEMPT:   breathe(lssu_pkg::STEP_ATTEMPT);
            lssu_pkg::FX_FAILED:    blink(lssu_pkg::COLOR_FAILED);
            lssu_pkg::FX_CONNECTED: blink(lssu_pkg::COLOR_CONNECTED);
            default:                frame = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
    r.red = strip[23:16];
    r.green = strip[15:8];
    r.blue = strip[7:0];
    r.refresh = frame;
  endtask

  task automatic add_item(input logic [1:0] cmd, input logic [1:0] link, input logic cal,
                          input logic typed, input lssu_pkg::result_t res);
    dir_row_t row;
    row = '0;
    row.cmd = cmd;
    row.link = link;
    row.cal = cal;
    row.typed = typed;
    row.res = res;
    dir_tab.push_back(row);
  endtask

  task automatic add_cfg(input logic [lssu_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    dir_tab.push_back(row);
  endtask

  // register write; the caller lowers the write enable after a batch
  task automatic cfg_write(input logic [lssu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      lssu_pkg::CFG_BLINK_COUNT: led_cfg.blink_count = data[3:0];
      lssu_pkg::CFG_BLINK_HALF:  led_cfg.blink_half = data;
      lssu_pkg::CFG_FAST_STEP:   led_cfg.fast_step = data;
      lssu_pkg::CFG_MID_STEP:    led_cfg.mid_step = data;
      lssu_pkg::CFG_SLOW_STEP:   led_cfg.slow_step = data;
      lssu_pkg::CFG_PEAK_LEVEL:  led_cfg.peak_level = data;
      default: ;
    endcase
  endtask

  // offer one item with random gaps, predict it once taken
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] link, input logic cal,
                           input logic typed, input lssu_pkg::result_t typed_res);
    lssu_pkg::result_t r;
    while (!in_no_gaps && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.link_status <= link;
    in_if.calibrating <= cal;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    animate_step(cmd, link, cal, r);
    strip_q.push_back(typed ? typed_res : r);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (strip_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each taken item, random stalls and one long hold-off
  initial begin
    lssu_pkg::result_t got;
    lssu_pkg::result_t want;
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = {out_if.red, out_if.green, out_if.blue, out_if.refresh};
        if (strip_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(got), 0);
        end else begin
          want = strip_q.pop_front();
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
          if (got.refresh !== want.refresh) begin
            report_mismatch("refresh", got.refresh, want.refresh);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 60;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= out_no_stall || ($urandom_range(99) >= 37);
      end
    end
  end

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("tb_led_status_animation_sequencer_unit: errors");
    $finish;
  end

  // stimulus
  initial begin
    lssu_pkg::cfg_t c;
    int unsigned n_items;
    int unsigned sent;
    int unsigned ev;
    int unsigned k;
    logic [1:0] cmd;
    logic [1:0] link;
    logic cal;

    in_if.valid = 1'b0;
    in_if.cmd = lssu_pkg::CMD_TICK;
    in_if.link_status = lssu_pkg::LINK_FAILED;
    in_if.calibrating = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lssu_pkg::CFG_BLINK_COUNT;
    cfg_wdata_i = '0;

    // directed: idle and ignored items at reset values
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b1,
             {8'd0, 8'd0, 8'd0, 1'b0});
    add_item(CMD_UNUSED, LINK_OTHER, 1'b1, 1'b1, {8'd0, 8'd0, 8'd0, 1'b0});
    add_item(lssu_pkg::CMD_LINK, LINK_OTHER, 1'b0, 1'b1, {8'd0, 8'd0, 8'd0, 1'b0});
    add_item(lssu_pkg::CMD_CAL, lssu_pkg::LINK_FAILED, 1'b0, 1'b1,
             {8'd0, 8'd0, 8'd0, 1'b0});
    // zero blink count, zero blink and slow delays, unit fast and mid delays, peak level 2
    add_cfg(lssu_pkg::CFG_BLINK_COUNT, 8'd0);
    add_cfg(lssu_pkg::CFG_BLINK_HALF, 8'd0);
    add_cfg(lssu_pkg::CFG_FAST_STEP, 8'd1);
    add_cfg(lssu_pkg::CFG_MID_STEP, 8'd1);
    add_cfg(lssu_pkg::CFG_SLOW_STEP, 8'd0);
    add_cfg(lssu_pkg::CFG_PEAK_LEVEL, 8'd2);
    // link updates replace each other, then a failed blink
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_CONNECTED, 1'b1, 1'b0, '0);
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, LINK_OTHER, 1'b1, 1'b1, {8'd120, 8'd0, 8'd0, 1'b1});
    // connected arriving during the blink is cleared with it
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_CONNECTED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b1,
             {8'd0, 8'd0, 8'd0, 1'b1});
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b1,
             {8'd120, 8'd0, 8'd0, 1'b1});
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b1,
             {8'd120, 8'd0, 8'd0, 1'b0});
    // calibration wins over attempting, breathes past the peak
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_ATTEMPTING, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_CAL, LINK_OTHER, 1'b1, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    // calibration off hands over to attempting
    add_item(lssu_pkg::CMD_CAL, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    // calibration does not preempt attempting
    add_item(lssu_pkg::CMD_CAL, lssu_pkg::LINK_FAILED, 1'b1, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    // connected ends attempting and starts its blink
    add_item(lssu_pkg::CMD_LINK, lssu_pkg::LINK_CONNECTED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_CAL, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);
    add_item(lssu_pkg::CMD_TICK, lssu_pkg::LINK_FAILED, 1'b0, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        cfg_we_i <= 1'b0;
        send_item(dir_tab[i].cmd, dir_tab[i].link, dir_tab[i].cal, dir_tab[i].typed,
                  dir_tab[i].res);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph)
        0: c = {4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd200};
        1: c = {lssu_pkg::RST_BLINK_COUNT, lssu_pkg::RST_BLINK_HALF,
                lssu_pkg::RST_FAST_STEP, lssu_pkg::RST_MID_STEP,
                lssu_pkg::RST_SLOW_STEP, lssu_pkg::RST_PEAK_LEVEL};
        2: c = {4'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2};
        3: c = {4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255};
        default: begin
          c.blink_count = 4'($urandom_range(0, 15));
          c.blink_half = 8'($urandom_range(0, 4));
          c.fast_step = 8'($urandom_range(0, 5));
          c.mid_step = 8'($urandom_range(0, 6));
          c.slow_step = 8'($urandom_range(0, 8));
          c.peak_level = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(2, 40));
        end
      endcase
      cfg_write(lssu_pkg::CFG_BLINK_COUNT, {4'd0, c.blink_count});
      cfg_write(lssu_pkg::CFG_BLINK_HALF, c.blink_half);
      cfg_write(lssu_pkg::CFG_FAST_STEP, c.fast_step);
      cfg_write(lssu_pkg::CFG_MID_STEP, c.mid_step);
      cfg_write(lssu_pkg::CFG_SLOW_STEP, c.slow_step);
      cfg_write(lssu_pkg::CFG_PEAK_LEVEL, c.peak_level);
      cfg_we_i <= 1'b0;

      // back-to-back sender against a held receiver, then stall-free stretches
      in_no_gaps = (ph == 4 || ph == 7);
      out_no_stall = (ph == 6 || ph == 7);
      if (ph == 4) hold_req = 1'b1;

      n_items = (ph == 0) ? 60 : (ph == 3) ? 250 : 110;
      ev = (ph % 3 == 0) ? 5 : (ph % 3 == 1) ? 12 : 25;
      sent = 0;
      while (sent < n_items) begin
        link = 2'($urandom);
        cal = 1'($urandom);
        k = $urandom_range(99);
        if (k < 100 - ev) begin
          cmd = lssu_pkg::CMD_TICK;
        end else begin
          k = $urandom_range(99);
          if (k < 45) begin
            cmd = lssu_pkg::CMD_LINK;
            link = ($urandom_range(9) == 0) ? LINK_OTHER : 2'($urandom_range(0, 2));
          end else if (k < 85) begin
            cmd = lssu_pkg::CMD_CAL;
          end else begin
            cmd = CMD_UNUSED;
          end
        end
        send_item(cmd, link, cal, 1'b0, '0);
        if (!(cmd == CMD_UNUSED || (cmd == lssu_pkg::CMD_LINK && link == LINK_OTHER))) begin
          sent++;
        end
      end
    end

    drain();
    in_no_gaps = 1'b0;
    out_no_stall = 1'b0;
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_led_status_animation_sequencer_unit: clean");
    end else begin
      $display("tb_led_status_animation_sequencer_unit: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lssu_pkg.sv
hw/rtl/lssu_if.sv
hw/rtl/lssu_cfg_regs.sv
hw/rtl/lssu_core.sv
hw/rtl/led_status_animation_sequencer_unit.sv
bench/tb_led_status_animation_sequencer_unit.sv
